// File: hw/rtl/fbpa_pkg.sv
// shared types, codes and defaults for the fixed block pool allocator
package fbpa_pkg;

    localparam int DEF_MAX_BLOCKS  = 256;
    localparam int DEF_COUNT_WIDTH = 32;

    // operation codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_TOO_BIG   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_POOL_BLOCKS  = 2'd0;
    localparam logic [1:0] CFG_OBJECT_BYTES = 2'd1;
    localparam logic [1:0] CFG_POOL_BASE    = 2'd2;

    localparam logic [8:0]  POOL_BLOCKS_RST  = 9'd256;
    localparam logic [12:0] OBJECT_BYTES_RST = 13'd8;
    localparam logic [31:0] POOL_BASE_RST    = 32'd0;

    localparam logic [12:0] MIN_STRIDE = 13'd8;
    localparam logic [8:0]  IN_USE_MAX = 9'd511;

    // one free list link entry
    typedef struct packed {
        logic       more;
        logic [7:0] link;
    } link_entry_t;

    // access request to the link memory
    typedef struct packed {
        logic        rd_en;
        logic [7:0]  rd_addr;
        logic        wr_en;
        logic [7:0]  wr_addr;
        link_entry_t wr_data;
    } link_req_t;

endpackage

// File: hw/rtl/fbpa_link_ram.sv
// free list link memory, one write and one registered read port
module fbpa_link_ram #(
    parameter int DEPTH = 256
) (
    input  logic                clk,
    input  fbpa_pkg::link_req_t req,
    output fbpa_pkg::link_entry_t rd_data
);
    import fbpa_pkg::*;

    localparam int AW = $clog2(DEPTH);

    link_entry_t mem [DEPTH];
    link_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/fbpa_addr_gen.sv
// block address generation: registered index times stride, then base add
module fbpa_addr_gen (
    input  logic        clk,
    input  logic        load,
    input  logic [8:0]  idx,
    input  logic [12:0] stride,
    input  logic [31:0] base,
    output logic [31:0] address
);
    import fbpa_pkg::*;

    logic [21:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= 22'(idx) * 22'(stride);
        end
    end

    assign address = base + 32'(product_reg);

endmodule

// File: hw/rtl/fixed_block_pool_allocator_core.sv
// fixed block pool allocator: LIFO free list in a link memory plus bump index
// result strobe in the done state, which follows the exec state entered at the accepting edge; one beat per item
// a new item can be accepted while the previous result is shown, but not in exec;
//   the registered link memory read (issued at accept) is followed by the index-times-stride product stage
// results cannot be stalled; each strobe lasts exactly one cycle
// reset: free list empty, bump index and all counters zero, config at defaults;
//   the link memory is not cleared, only pushed entries are ever read
module fixed_block_pool_allocator_core #(
    parameter int MAX_BLOCKS  = fbpa_pkg::DEF_MAX_BLOCKS,
    parameter int COUNT_WIDTH = fbpa_pkg::DEF_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [12:0] request_size,
    input  logic [7:0]  block_index,
    // result beat
    output logic        result_valid,
    output logic [7:0]  granted_index,
    output logic [31:0] granted_address,
    output logic [1:0]  status,
    output logic [8:0]  in_use_count,
    output logic [31:0] allocation_count,
    output logic [31:0] release_count,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import fbpa_pkg::*;

    // every 8-bit index is legal once the pool covers 256 blocks
    localparam bit         ALL_IDX_OK = (MAX_BLOCKS >= 256);
    localparam int         LINK_DEPTH = ALL_IDX_OK ? 256 : MAX_BLOCKS;
    localparam logic [7:0] IDX_BOUND  = ALL_IDX_OK ? 8'd0 : 8'(MAX_BLOCKS);
    // fresh index limit cap; pool_blocks is 9 bits so 511 never bites
    localparam logic [8:0] LIMIT_CAP  = (MAX_BLOCKS < 512) ? 9'(MAX_BLOCKS) : 9'd511;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg, state_next;

    // configuration
    logic [8:0]  pool_blocks_reg;
    logic [12:0] object_bytes_reg;
    logic [31:0] pool_base_reg;

    // allocator state
    logic [7:0]             free_head_reg, free_head_next;
    logic                   nonempty_reg, nonempty_next;
    logic [8:0]             fresh_reg, fresh_next;
    logic [8:0]             in_use_reg, in_use_next;
    logic [COUNT_WIDTH-1:0] alloc_total_reg, alloc_total_next;
    logic [COUNT_WIDTH-1:0] release_total_reg, release_total_next;

    // latched command
    logic        op_reg;
    logic [12:0] size_reg;
    logic [7:0]  bidx_reg;

    // result holding
    logic [1:0] status_reg, status_next;
    logic       granted_reg, granted_next;
    logic [8:0] idx_reg, idx_next;

    logic        accept;
    logic        exec;
    link_req_t   link_req;
    link_entry_t link_rd;
    logic [12:0] stride;
    logic [8:0]  limit;
    logic        head_ok;
    logic        ret_ok;
    logic [31:0] block_address;
    logic [63:0] alloc_wide;
    logic [63:0] release_wide;

    assign busy      = (state_reg == S_EXEC);
    assign accept    = start && !busy;
    assign exec      = (state_reg == S_EXEC);
    assign cfg_ready = 1'b1;

    // ---------------- configuration writes ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_blocks_reg  <= POOL_BLOCKS_RST;
            object_bytes_reg <= OBJECT_BYTES_RST;
            pool_base_reg    <= POOL_BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_BLOCKS:  pool_blocks_reg  <= cfg_data[8:0];
                CFG_OBJECT_BYTES: object_bytes_reg <= cfg_data[12:0];
                CFG_POOL_BASE:    pool_base_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = start ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // command fields, held for the exec cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            size_reg <= request_size;
            bidx_reg <= block_index;
        end
    end

    // ---------------- link memory ----------------
    // head link is read at accept so it is ready in exec; a push writes in exec,
    // and no read is in flight then, so no forwarding path is needed
    always_comb
    begin
        link_req.rd_en        = accept;
        link_req.rd_addr      = free_head_reg;
        link_req.wr_en        = exec && (op_reg == OP_RELEASE) && ret_ok;
        link_req.wr_addr      = bidx_reg;
        link_req.wr_data.more = nonempty_reg;
        link_req.wr_data.link = free_head_reg;
    end

    fbpa_link_ram #(
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .req     (link_req),
        .rd_data (link_rd)
    );

    // ---------------- exec: pop, bump or push ----------------
    assign stride  = (object_bytes_reg < MIN_STRIDE) ? MIN_STRIDE : object_bytes_reg;
    assign limit   = (pool_blocks_reg > LIMIT_CAP) ? LIMIT_CAP : pool_blocks_reg;
    assign head_ok = ALL_IDX_OK || (free_head_reg < IDX_BOUND);
    assign ret_ok  = ALL_IDX_OK || (bidx_reg < IDX_BOUND);

    always_comb
    begin
        free_head_next     = free_head_reg;
        nonempty_next      = nonempty_reg;
        fresh_next         = fresh_reg;
        in_use_next        = in_use_reg;
        alloc_total_next   = alloc_total_reg;
        release_total_next = release_total_reg;
        status_next        = ST_OK;
        granted_next       = 1'b0;
        idx_next           = 9'd0;

        if (op_reg == OP_ALLOC)
        begin
            if (size_reg > object_bytes_reg)
            begin
                // oversize is checked before anything else
                status_next = ST_TOO_BIG;
            end
            else if (nonempty_reg && head_ok)
            begin
                // pop the free list head
                granted_next   = 1'b1;
                idx_next       = {1'b0, free_head_reg};
                free_head_next = link_rd.link;
                nonempty_next  = link_rd.more;
            end
            else if (fresh_reg < limit)
            begin
                // hand out a never-used block
                granted_next = 1'b1;
                idx_next     = fresh_reg;
                fresh_next   = fresh_reg + 9'd1;
            end
            else
            begin
                status_next = ST_EXHAUSTED;
            end

            if (granted_next)
            begin
                if (in_use_reg < IN_USE_MAX)
                begin
                    in_use_next = in_use_reg + 9'd1;
                end
                alloc_total_next = alloc_total_reg + COUNT_WIDTH'(1);
            end
        end
        else if (ret_ok)
        begin
            // push, stray or double returns included
            free_head_next = bidx_reg;
            nonempty_next  = 1'b1;
            if (in_use_reg != 9'd0)
            begin
                in_use_next = in_use_reg - 9'd1;
            end
            release_total_next = release_total_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            free_head_reg     <= 8'd0;
            nonempty_reg      <= 1'b0;
            fresh_reg         <= 9'd0;
            in_use_reg        <= 9'd0;
            alloc_total_reg   <= '0;
            release_total_reg <= '0;
            status_reg        <= ST_OK;
            granted_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec)
            begin
                free_head_reg     <= free_head_next;
                nonempty_reg      <= nonempty_next;
                fresh_reg         <= fresh_next;
                in_use_reg        <= in_use_next;
                alloc_total_reg   <= alloc_total_next;
                release_total_reg <= release_total_next;
                status_reg        <= status_next;
                granted_reg       <= granted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            idx_reg <= idx_next;
        end
    end

    // ---------------- address: product registered in exec ----------------
    fbpa_addr_gen u_addr_gen (
        .clk     (clk),
        .load    (exec),
        .idx     (idx_next),
        .stride  (stride),
        .base    (pool_base_reg),
        .address (block_address)
    );

    // ---------------- result beat ----------------
    assign alloc_wide   = 64'(alloc_total_reg);
    assign release_wide = 64'(release_total_reg);

    assign result_valid     = (state_reg == S_DONE);
    assign granted_index    = granted_reg ? idx_reg[7:0] : 8'd0;
    assign granted_address  = granted_reg ? block_address : 32'd0;
    assign status           = status_reg;
    assign in_use_count     = in_use_reg;
    assign allocation_count = alloc_wide[31:0];
    assign release_count    = release_wide[31:0];

endmodule

// File: bench/tb_fixed_block_pool_allocator_core.sv
// self-checking testbench for the fixed block pool allocator core
module tb_fixed_block_pool_allocator_core;

    import fbpa_pkg::*;

    // pool size of the instance under test; the predictor mirrors it
    localparam int POOL_SLOTS = DEF_MAX_BLOCKS;
    // quiet cycles needed before a register write, and the tail wait at the end
    localparam int SETTLE_CYCLES = 3;
    localparam int DRAIN_CYCLES  = 8;
    // at most this many beats wait in line ahead of the driver
    localparam int LINE_DEPTH = 4;

    // a beat for the driver: either an allocator command or a register write
    typedef enum logic {BEAT_CMD, BEAT_REG} beat_kind_t;

    typedef struct {
        beat_kind_t  kind;
        logic        op;
        logic [12:0] size;
        logic [7:0]  blk;
        logic [1:0]  reg_idx;
        logic [31:0] reg_data;
    } beat_t;

    // one result beat as the allocator should report it
    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] addr;
        logic [1:0]  stat;
        logic [8:0]  in_use;
        logic [31:0] allocs;
        logic [31:0] releases;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        operation = OP_ALLOC;
    logic [12:0] request_size = '0;
    logic [7:0]  block_index = '0;
    logic        result_valid;
    logic [7:0]  granted_index;
    logic [31:0] granted_address;
    logic [1:0]  status;
    logic [8:0]  in_use_count;
    logic [31:0] allocation_count;
    logic [31:0] release_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_POOL_BLOCKS;
    logic [31:0] cfg_data = '0;

    fixed_block_pool_allocator_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (operation),
        .request_size     (request_size),
        .block_index      (block_index),
        .result_valid     (result_valid),
        .granted_index    (granted_index),
        .granted_address  (granted_address),
        .status           (status),
        .in_use_count     (in_use_count),
        .allocation_count (allocation_count),
        .release_count    (release_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow allocator: configuration, free list and counters
    // ------------------------------------------------------------------
    logic [8:0]  m_pool_blocks  = POOL_BLOCKS_RST;
    logic [12:0] m_object_bytes = OBJECT_BYTES_RST;
    logic [31:0] m_pool_base    = POOL_BASE_RST;
    logic [7:0]  m_link_next [POOL_SLOTS];
    logic        m_link_more [POOL_SLOTS];
    logic [7:0]  m_free_head = '0;
    logic        m_list_live = 1'b0;
    logic [8:0]  m_fresh     = '0;
    logic [8:0]  m_in_use    = '0;
    logic [31:0] m_alloc_total   = '0;
    logic [31:0] m_release_total = '0;

    // works out the result of one accepted command and advances the shadow state
    function automatic grant_t predict_grant(input logic op, input logic [12:0] size,
                                             input logic [7:0] blk);
        grant_t      g;
        logic [12:0] stride;
        logic [8:0]  limit;
        logic        granted;

        g       = '0;
        granted = 1'b0;
        stride  = (m_object_bytes < MIN_STRIDE) ? MIN_STRIDE : m_object_bytes;
        limit   = (m_pool_blocks > 9'(POOL_SLOTS)) ? 9'(POOL_SLOTS) : m_pool_blocks;
        if (op == OP_ALLOC)
        begin
            // size is checked ahead of any free block
            if (size > m_object_bytes)
                g.stat = ST_TOO_BIG;
            else if (m_list_live)
            begin
                g.idx       = m_free_head;
                m_free_head = m_link_next[g.idx];
                m_list_live = m_link_more[g.idx];
                granted     = 1'b1;
            end
            else if (m_fresh < limit)
            begin
                g.idx   = m_fresh[7:0];
                m_fresh = m_fresh + 9'd1;
                granted = 1'b1;
            end
            else
                g.stat = ST_EXHAUSTED;
            if (granted)
            begin
                g.stat = ST_OK;
                if (m_in_use != IN_USE_MAX)
                    m_in_use = m_in_use + 9'd1;
                m_alloc_total = m_alloc_total + 32'd1;
                g.addr = m_pool_base + {24'd0, g.idx} * {19'd0, stride};
            end
        end
        else
        begin
            // any index is pushed, in use or not
            m_link_next[blk] = m_free_head;
            m_link_more[blk] = m_list_live;
            m_free_head      = blk;
            m_list_live      = 1'b1;
            if (m_in_use != 9'd0)
                m_in_use = m_in_use - 9'd1;
            m_release_total = m_release_total + 32'd1;
            g.stat = ST_OK;
        end
        g.in_use   = m_in_use;
        g.allocs   = m_alloc_total;
        g.releases = m_release_total;
        return g;
    endfunction

    // ------------------------------------------------------------------
    // shared bookkeeping between stimulus, driver and monitor
    // ------------------------------------------------------------------
    beat_t       pending [$];     // beats waiting for the driver
    grant_t      grants_due [$];  // results owed by the block, oldest first
    logic [7:0]  held [$];        // blocks granted and not yet handed back
    bit          held_mark [POOL_SLOTS];
    logic [12:0] plan_object_bytes = OBJECT_BYTES_RST;
    int          gap_pct = 0;     // chance in percent that the sender idles
    int          gap_left = 0;
    logic        cmd_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    int          quiet_cycles = 0;
    int          failures = 0;

    task automatic queue_cmd(input logic op, input logic [12:0] size, input logic [7:0] blk);
        beat_t b;

        b = '{kind: BEAT_CMD, op: op, size: size, blk: blk, reg_idx: CFG_POOL_BLOCKS,
              reg_data: '0};
        while (pending.size() >= LINE_DEPTH)
            @(posedge clk);
        pending.push_back(b);
    endtask

    // register write; unused upper data bits carry noise
    task automatic queue_reg(input logic [1:0] idx, input logic [31:0] value);
        beat_t       b;
        logic [31:0] noise;

        noise = '0;
        if (idx == CFG_POOL_BLOCKS)
            noise = $urandom & 32'hFFFF_FE00;
        else if (idx == CFG_OBJECT_BYTES)
        begin
            noise = $urandom & 32'hFFFF_E000;
            plan_object_bytes = value[12:0];
        end
        b = '{kind: BEAT_REG, op: OP_ALLOC, size: '0, blk: '0, reg_idx: idx,
              reg_data: value | noise};
        while (pending.size() >= LINE_DEPTH)
            @(posedge clk);
        pending.push_back(b);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: inputs move on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        beat_t b;
        logic  go_cmd;
        logic  go_cfg;

        if (rst_n)
        begin
            if ((start && !cmd_taken) || (cfg_valid && !cfg_taken))
            begin
                // current beat has not been taken yet, hold it
            end
            else
            begin
                go_cmd = 1'b0;
                go_cfg = 1'b0;
                if (gap_left != 0)
                    gap_left = gap_left - 1;
                else if (pending.size() != 0)
                begin
                    if (pending[0].kind == BEAT_REG)
                    begin
                        // register writes only land on an idle block
                        if (quiet_cycles >= SETTLE_CYCLES)
                        begin
                            b = pending.pop_front();
                            go_cfg = 1'b1;
                        end
                    end
                    else if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                        gap_left = $urandom_range(0, 5);
                    else
                    begin
                        b = pending.pop_front();
                        go_cmd = 1'b1;
                    end
                end
                // single nonblocking update per signal in this step
                start     <= go_cmd;
                cfg_valid <= go_cfg;
                if (go_cmd)
                begin
                    operation    <= b.op;
                    request_size <= b.size;
                    block_index  <= b.blk;
                end
                if (go_cfg)
                begin
                    cfg_index <= b.reg_idx;
                    cfg_data  <= b.reg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks result beats, predicts accepted commands, tracks writes
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        grant_t want;

        if (rst_n)
        begin
            // compare before predicting, a result never shares an edge with its own command
            if (result_valid)
            begin
                if (grants_due.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    check_field("granted_index", 32'(want.idx), 32'(granted_index));
                    check_field("granted_address", want.addr, granted_address);
                    check_field("status", 32'(want.stat), 32'(status));
                    check_field("in_use_count", 32'(want.in_use), 32'(in_use_count));
                    check_field("allocation_count", want.allocs, allocation_count);
                    check_field("release_count", want.releases, release_count);
                end
            end
            if (start && !busy)
            begin
                want = predict_grant(operation, request_size, block_index);
                grants_due.push_back(want);
                // remember live blocks so stimulus can hand them back
                if (operation == OP_ALLOC && want.stat == ST_OK && !held_mark[want.idx])
                begin
                    held.push_back(want.idx);
                    held_mark[want.idx] = 1'b1;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_POOL_BLOCKS:  m_pool_blocks  = cfg_data[8:0];
                    CFG_OBJECT_BYTES: m_object_bytes = cfg_data[12:0];
                    CFG_POOL_BASE:    m_pool_base    = cfg_data;
                    default: ;
                endcase
            end
            cmd_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;
            if (grants_due.size() == 0 && !start && !result_valid)
                quiet_cycles <= quiet_cycles + 1;
            else
                quiet_cycles <= 0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed corner cases, random phases, then the saturation run
    // ------------------------------------------------------------------
    initial
    begin
        logic [8:0]  phase_pool [7];
        logic [12:0] phase_obj [7];
        logic [31:0] phase_base [7];
        int          phase_gap [7];
        int unsigned pick;
        int unsigned slot;
        logic [12:0] sz;
        logic [7:0]  blk;

        phase_pool = '{9'd4, 9'd0, 9'd16, 9'd511, 9'd256, 9'd1, 9'd0};
        phase_obj  = '{13'd1, 13'd8191, 13'd9, 13'd4096, 13'd7, 13'd0, 13'd0};
        phase_base = '{32'h0000_1000, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_F000,
                       32'h0, 32'h0};
        phase_gap  = '{10, 30, 0, 15, 40, 10, 20};
        phase_pool[6] = 9'($urandom_range(1, 300));
        phase_obj[6]  = 13'($urandom_range(1, 4096));

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: stray return into an empty pool, oversize, list pop, fresh block
        queue_cmd(OP_RELEASE, 13'd8191, 8'd7);
        queue_cmd(OP_ALLOC, 13'd8191, 8'd255);
        queue_cmd(OP_ALLOC, 13'd8, 8'd0);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);

        // three-block pool, odd stride, base near the top so addresses wrap
        queue_reg(CFG_POOL_BLOCKS, 32'd3);
        queue_reg(CFG_OBJECT_BYTES, 32'd9);
        queue_reg(CFG_POOL_BASE, 32'hFFFF_FFF0);
        queue_cmd(OP_ALLOC, 13'd9, 8'd0);
        queue_cmd(OP_ALLOC, 13'd10, 8'd0);
        queue_cmd(OP_ALLOC, 13'd1, 8'd255);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);         // pool exhausted
        queue_cmd(OP_RELEASE, 13'd8191, 8'd1);
        queue_cmd(OP_RELEASE, 13'd0, 8'd0);
        queue_cmd(OP_ALLOC, 13'd10, 8'd0);        // oversize wins over a free block
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);         // exhausted again

        // empty pool limit and zero object size
        queue_reg(CFG_POOL_BLOCKS, 32'd0);
        queue_reg(CFG_OBJECT_BYTES, 32'd0);
        queue_reg(CFG_POOL_BASE, 32'd0);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);
        queue_cmd(OP_ALLOC, 13'd1, 8'd0);
        queue_cmd(OP_RELEASE, 13'd0, 8'd2);
        queue_cmd(OP_ALLOC, 13'd0, 8'd0);

        // limit above the pool size saturates, largest object size, top base
        queue_reg(CFG_POOL_BLOCKS, 32'd511);
        queue_reg(CFG_OBJECT_BYTES, 32'd8191);
        queue_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        queue_cmd(OP_ALLOC, 13'd8191, 8'd0);
        queue_cmd(OP_RELEASE, 13'd0, 8'd255);
        queue_cmd(OP_ALLOC, 13'd4096, 8'd0);

        // random phases: mostly grant/return traffic on live blocks
        for (int p = 0; p < 7; p++)
        begin
            queue_reg(CFG_POOL_BLOCKS, 32'(phase_pool[p]));
            queue_reg(CFG_OBJECT_BYTES, 32'(phase_obj[p]));
            queue_reg(CFG_POOL_BASE, (phase_base[p] == 32'h0) ? $urandom : phase_base[p]);
            gap_pct = phase_gap[p];
            repeat (160)
            begin
                pick = $urandom_range(0, 99);
                if (pick >= 55 && pick < 90 && held.size() != 0)
                begin
                    slot = $urandom_range(0, held.size() - 1);
                    blk = held[slot];
                    held.delete(slot);
                    held_mark[blk] = 1'b0;
                    queue_cmd(OP_RELEASE, 13'($urandom), blk);
                end
                else if (pick >= 90 && pick < 96)
                begin
                    // oversize noise, unless the object size is already at its largest
                    if (plan_object_bytes == 13'h1FFF)
                        sz = 13'h1FFF;
                    else
                        sz = 13'($urandom_range(32'(plan_object_bytes) + 1, 8191));
                    queue_cmd(OP_ALLOC, sz, 8'($urandom));
                end
                else if (pick >= 96 && p == 6)
                    // stray return of an arbitrary block, kept to the last phase since
                    // duplicates in the free list can loop it forever
                    queue_cmd(OP_RELEASE, 13'($urandom), 8'($urandom));
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        sz = plan_object_bytes;
                    else
                        sz = 13'($urandom_range(0, 32'(plan_object_bytes)));
                    queue_cmd(OP_ALLOC, sz, 8'($urandom));
                end
            end
        end

        // double return of one block loops the free list on itself, so grants never
        // run dry and the in-use count climbs to its ceiling; no idling from here on
        queue_reg(CFG_POOL_BLOCKS, 32'd256);
        queue_reg(CFG_OBJECT_BYTES, 32'd8);
        queue_reg(CFG_POOL_BASE, $urandom);
        gap_pct = 0;
        queue_cmd(OP_RELEASE, 13'd0, 8'd0);
        queue_cmd(OP_RELEASE, 13'd0, 8'd0);
        repeat (530)
            queue_cmd(OP_ALLOC, 13'($urandom_range(0, 8)), 8'($urandom));

        // drain: every beat taken, every result back, then a short tail
        while (pending.size() != 0 || start || cfg_valid)
            @(posedge clk);
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // hard stop in case a handshake or a result never arrives
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
